### hw/rtl/ewea_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the EMG window energy average block.
// Used by every module under hw/rtl; depends on nothing else.
package ewea_pkg;

    localparam int WINDOW      = 60;
    localparam int CHANNELS    = 8;
    localparam int CH_FIELDS   = 8;

    localparam int SAMPLE_W    = 8;
    localparam int SQ_W        = 2 * SAMPLE_W - 1;
    localparam int ENERGY_W    = 18;
    localparam int SUM_W       = 23;
    localparam int AVG_W       = 24;
    localparam int INDEX_W     = 16;
    localparam int STAMP_W     = 64;
    localparam int LIMIT_W     = 16;
    localparam int FRAC_BITS   = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd250;

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
    localparam logic [INDEX_W-1:0] WINDOW_COUNT = INDEX_W'(WINDOW);

    // Average = floor(sum * 2^FRAC_BITS / WINDOW) through a rounded-up reciprocal.
    localparam int WIN_LOG   = $clog2(WINDOW);
    localparam int AVG_SHIFT = SUM_W + WIN_LOG;
    localparam int AVG_K     = AVG_SHIFT + FRAC_BITS;
    localparam int MUL_W     = SUM_W + 8;
    localparam int PROD_W    = SUM_W + MUL_W;
    localparam logic [63:0] AVG_MUL_FULL =
        ((64'd1 << AVG_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [MUL_W-1:0] AVG_MUL = AVG_MUL_FULL[MUL_W-1:0];

    localparam int IN_CH_W       = CH_FIELDS * SAMPLE_W;
    localparam int IN_TDATA_W    = ((IN_CH_W + STAMP_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W  = INDEX_W + SUM_W + AVG_W + STAMP_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic             emit;
        logic             clear;
        logic             sub;
        logic [PTR_W-1:0] ptr;
    } t_ctrl;

endpackage

### hw/rtl/ewea_lane.sv
`timescale 1ns / 1ps
// One channel lane: registered square of a signed 8-bit sample.
// Depends on ewea_pkg.
module ewea_lane (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [ewea_pkg::SAMPLE_W-1:0] i_sample,
    output logic [ewea_pkg::SQ_W-1:0]        o_square
);
    import ewea_pkg::*;

    logic signed [2*SAMPLE_W-1:0] n_prod;
    logic [SQ_W-1:0]              r_square;

    assign n_prod = i_sample * i_sample;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_square <= n_prod[SQ_W-1:0];
        end
    end

    assign o_square = r_square;
endmodule

### hw/rtl/ewea_merge.sv
`timescale 1ns / 1ps
// Merge stage: adds the per-lane squares into one sample energy, registered.
// Depends on ewea_pkg.
module ewea_merge (
    input  logic                                      i_clk,
    input  logic                                      i_en,
    input  logic [ewea_pkg::CHANNELS-1:0][ewea_pkg::SQ_W-1:0] i_square,
    output logic [ewea_pkg::ENERGY_W-1:0]             o_energy
);
    import ewea_pkg::*;

    logic [ENERGY_W-1:0] n_energy;
    logic [ENERGY_W-1:0] r_energy;

    always_comb begin
        n_energy = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            n_energy = n_energy + ENERGY_W'(i_square[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_energy <= n_energy;
        end
    end

    assign o_energy = r_energy;
endmodule

### hw/rtl/ewea_accum.sv
`timescale 1ns / 1ps
// Running window sum with the energy ring memory.
// Depends on ewea_pkg.
module ewea_accum (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  ewea_pkg::t_ctrl                 i_ctrl,
    input  logic [ewea_pkg::ENERGY_W-1:0]   i_energy,
    input  logic [ewea_pkg::PTR_W-1:0]      i_rd_addr,
    output logic [ewea_pkg::SUM_W-1:0]      o_window_sum
);
    import ewea_pkg::*;

    logic [ENERGY_W-1:0] r_ring [WINDOW];
    logic [ENERGY_W-1:0] r_rd;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [SUM_W-1:0]    n_base;
    logic [SUM_W-1:0]    r_window_sum;
    logic                n_wr;

    assign n_wr   = i_load && i_ctrl.emit;
    assign n_base = i_ctrl.clear ? '0 : r_sum;

    always_comb begin
        n_sum = r_sum;
        if (i_load) begin
            if (i_ctrl.emit) begin
                n_sum = n_base - (i_ctrl.sub ? SUM_W'(r_rd) : '0) + SUM_W'(i_energy);
            end else begin
                n_sum = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_ring[i_ctrl.ptr] <= i_energy;
        end
        if (n_wr && (i_ctrl.ptr == i_rd_addr)) begin
            r_rd <= i_energy;
        end else begin
            r_rd <= r_ring[i_rd_addr];
        end
        if (n_wr) begin
            r_window_sum <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_window_sum = r_window_sum;
endmodule

### hw/rtl/emg_window_energy_average.sv
`timescale 1ns / 1ps
// EMG window energy average top level: sample counting, lane pipeline and output word.
// Depends on ewea_pkg, ewea_lane, ewea_merge and ewea_accum.
//
// The block takes one sample word per clock while ready is high and returns one result word
// per clock while the output is taken, through registered stages: squares in the channel lanes,
// the merge adder, the running sum with its ring memory read ahead of the sum update, and the
// reciprocal multiply that forms the average in the output register. Ready drops only when every
// pipeline stage holds a word and the output is not taken. A sample taken once the count has
// reached the capture limit gives no result word. The capture limit is written through
// i_cfg_wr_en and applies from the next sample; write it only while no sample is in flight.
module emg_window_energy_average (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [ewea_pkg::LIMIT_W-1:0]          i_cfg_wr_data,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // ch0, ch1, ch2, ch3, ch4, ch5, ch6, ch7, stamp_in
    input  logic [ewea_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // restart
    input  logic                                  i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // sample_index, window_sum, window_average, stamp_out, zero pad
    output logic [ewea_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);
    import ewea_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic [INDEX_W-1:0] r_count;
    logic [INDEX_W-1:0] n_count;
    logic [PTR_W-1:0]   r_ptr;
    logic [PTR_W-1:0]   n_ptr;
    logic [INDEX_W-1:0] n_eff_count;
    logic [PTR_W-1:0]   n_eff_ptr;
    logic               n_emit;
    logic               n_accept;
    t_ctrl              n_ctrl0;

    logic en1, en2, en3, en4;

    logic               r_v1, r_v2, r_v3, r_v4;
    t_ctrl              r_ctrl1, r_ctrl2;
    logic [INDEX_W-1:0] r_idx1, r_idx2, r_idx3, r_idx4;
    logic [STAMP_W-1:0] r_stamp1, r_stamp2, r_stamp3, r_stamp4;
    logic [SUM_W-1:0]   r_sum4;
    logic [PROD_W-1:0]  r_prod4;

    logic [CHANNELS-1:0][SQ_W-1:0] w_square;
    logic [ENERGY_W-1:0]           w_energy;
    logic [SUM_W-1:0]              w_window_sum;
    logic [PTR_W-1:0]              w_rd_addr;
    logic [AVG_W-1:0]              w_average;

    assign en4 = !r_v4 || i_m_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_s_tready = en1;
    assign n_accept   = i_s_tvalid && en1;

    assign n_eff_count = i_s_tuser ? '0 : r_count;
    assign n_eff_ptr   = i_s_tuser ? '0 : r_ptr;
    assign n_emit      = n_eff_count < r_limit;

    assign n_ctrl0.emit  = n_emit;
    assign n_ctrl0.clear = i_s_tuser;
    assign n_ctrl0.sub   = n_eff_count >= WINDOW_COUNT;
    assign n_ctrl0.ptr   = n_eff_ptr;

    always_comb begin
        n_count = r_count;
        n_ptr   = r_ptr;
        if (n_accept) begin
            n_count = n_emit ? n_eff_count + 1'b1 : n_eff_count;
            if (n_emit) begin
                n_ptr = (n_eff_ptr == PTR_LAST) ? '0 : n_eff_ptr + 1'b1;
            end else begin
                n_ptr = n_eff_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_count <= '0;
            r_ptr   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            r_count <= n_count;
            r_ptr   <= n_ptr;
            if (en1) begin
                r_v1 <= n_accept && (n_emit || i_s_tuser);
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2 && r_ctrl2.emit;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_ctrl1  <= n_ctrl0;
            r_idx1   <= n_eff_count;
            r_stamp1 <= i_s_tdata[IN_CH_W +: STAMP_W];
        end
        if (en2) begin
            r_ctrl2  <= r_ctrl1;
            r_idx2   <= r_idx1;
            r_stamp2 <= r_stamp1;
        end
        if (en3) begin
            r_idx3   <= r_idx2;
            r_stamp3 <= r_stamp2;
        end
        if (en4) begin
            r_idx4   <= r_idx3;
            r_stamp4 <= r_stamp3;
            r_sum4   <= w_window_sum;
            r_prod4  <= PROD_W'(w_window_sum) * PROD_W'(AVG_MUL);
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        ewea_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en1),
            .i_sample ($signed(i_s_tdata[g*SAMPLE_W +: SAMPLE_W])),
            .o_square (w_square[g])
        );
    end

    ewea_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (en2),
        .i_square (w_square),
        .o_energy (w_energy)
    );

    assign w_rd_addr = en2 ? r_ctrl1.ptr : r_ctrl2.ptr;

    ewea_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (en3 && r_v2),
        .i_ctrl       (r_ctrl2),
        .i_energy     (w_energy),
        .i_rd_addr    (w_rd_addr),
        .o_window_sum (w_window_sum)
    );

    assign w_average  = r_prod4[AVG_SHIFT +: AVG_W];
    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = OUT_TDATA_W'({r_stamp4, w_average, r_sum4, r_idx4});
endmodule

### dv/ewea_energy_checker.sv
`timescale 1ns / 1ps
// Result checker for the EMG window energy average block: predicts every result word from
// the accepted sample words and compares it with the output channel. Depends on ewea_pkg.
module ewea_energy_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ewea_pkg::LIMIT_W-1:0]        i_cfg_wr_data,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    // ch0, ch1, ch2, ch3, ch4, ch5, ch6, ch7, stamp_in
    input  logic [ewea_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // restart
    input  logic                                i_s_tuser,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    // sample_index, window_sum, window_average, stamp_out, zero pad
    input  logic [ewea_pkg::OUT_TDATA_W-1:0]    i_m_tdata,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import ewea_pkg::*;

    localparam int SUM_LSB   = INDEX_W;
    localparam int AVG_LSB   = INDEX_W + SUM_W;
    localparam int STAMP_LSB = INDEX_W + SUM_W + AVG_W;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [SUM_W-1:0]   sum;
        logic [AVG_W-1:0]   avg;
        logic [STAMP_W-1:0] stamp;
    } t_energy_result;

    t_energy_result      expected_results[$];
    logic [ENERGY_W-1:0] energy_hist [WINDOW];
    logic [SUM_W-1:0]    window_total;
    logic [INDEX_W-1:0]  taken_count;
    logic [PTR_W-1:0]    write_slot;
    logic [LIMIT_W-1:0]  capture_limit;

    always @(posedge i_clk) begin : track
        t_energy_result             got;
        t_energy_result             want;
        logic signed [SAMPLE_W-1:0] lane;
        logic [ENERGY_W-1:0]        energy;
        if (!i_rst_n) begin
            window_total  = '0;
            taken_count   = '0;
            write_slot    = '0;
            capture_limit = LIMIT_RESET;
            expected_results.delete();
            o_fail_count  = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.index = i_m_tdata[0 +: INDEX_W];
                got.sum   = i_m_tdata[SUM_LSB +: SUM_W];
                got.avg   = i_m_tdata[AVG_LSB +: AVG_W];
                got.stamp = i_m_tdata[STAMP_LSB +: STAMP_W];
                if (expected_results.size() == 0) begin
                    $error("result word with no sample waiting: sample_index %0d", got.index);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.index !== want.index) begin
                        $error("sample_index mismatch: expected %0d, actual %0d",
                               want.index, got.index);
                        o_fail_count++;
                    end
                    if (got.sum !== want.sum) begin
                        $error("window_sum mismatch: expected %0d, actual %0d",
                               want.sum, got.sum);
                        o_fail_count++;
                    end
                    if (got.avg !== want.avg) begin
                        $error("window_average mismatch: expected %0d, actual %0d",
                               want.avg, got.avg);
                        o_fail_count++;
                    end
                    if (got.stamp !== want.stamp) begin
                        $error("stamp_out mismatch: expected %h, actual %h",
                               want.stamp, got.stamp);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                capture_limit = i_cfg_wr_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser) begin
                    window_total = '0;
                    taken_count  = '0;
                    write_slot   = '0;
                end
                // Past the limit a sample leaves the window and the count untouched.
                if (taken_count < capture_limit) begin
                    want.index = taken_count;
                    want.sum   = window_total;
                    want.avg   = AVG_W'((64'(window_total) << FRAC_BITS) / 64'(WINDOW));
                    want.stamp = i_s_tdata[IN_CH_W +: STAMP_W];
                    expected_results.push_back(want);
                    energy = '0;
                    for (int c = 0; c < CHANNELS; c++) begin
                        lane   = i_s_tdata[c*SAMPLE_W +: SAMPLE_W];
                        energy = energy + ENERGY_W'(int'(lane) * int'(lane));
                    end
                    if (taken_count >= WINDOW_COUNT) begin
                        window_total = window_total - SUM_W'(energy_hist[write_slot]);
                    end
                    energy_hist[write_slot] = energy;
                    window_total = window_total + SUM_W'(energy);
                    write_slot   = (write_slot == PTR_LAST) ? '0 : write_slot + 1'b1;
                    taken_count++;
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the EMG window energy average block: clock, reset, sample stimulus,
// output back-pressure and the verdict. Depends on ewea_pkg and ewea_energy_checker.
module tb_top;
    import ewea_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int TARGET_ITEMS   = 1050;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0]     cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                   s_tuser     = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int sent_count   = 0;
    int idle_cycles  = 0;
    int m_stall_left = 0;
    bit s_idle_on    = 1'b0;
    bit m_idle_on    = 1'b0;

    always #5 clk = ~clk;

    emg_window_energy_average dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata)
    );

    ewea_energy_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IN_CH_W-1:0] random_lanes();
        logic [IN_CH_W-1:0] lanes;
        lanes = IN_CH_W'({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0: lanes = {CH_FIELDS{8'h80}};
            1: lanes = {CH_FIELDS{8'h7f}};
            2: lanes = '0;
            3: begin
                for (int c = 0; c < CH_FIELDS; c++) begin
                    lanes[c*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(0, 6) - 3);
                end
            end
            default: ;
        endcase
        return lanes;
    endfunction

    function automatic logic [STAMP_W-1:0] random_stamp();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return STAMP_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic send_sample(input logic restart, input logic [IN_CH_W-1:0] lanes,
                               input logic [STAMP_W-1:0] stamp);
        int gap;
        gap = pick_gap(s_idle_on);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = restart;
        s_tdata  = IN_TDATA_W'({stamp, lanes});
        do @(posedge clk); while (!s_tready);
        sent_count++;
    endtask

    // Waits until every predicted word has come out, then lets the pipeline run dry.
    task automatic drain_block();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_limit(input logic [LIMIT_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    always @(negedge clk) begin
        if (m_stall_left > 0) begin
            m_stall_left--;
        end else begin
            m_stall_left = pick_gap(m_idle_on);
        end
        m_tready <= (m_stall_left == 0);
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int               phase;
        int               run_len;
        bit               full_scale;
        logic             restart;
        logic [LIMIT_W-1:0] limit;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // The reset limit is in force: extremes, early windows and restarts.
        send_sample(1'b1, {CH_FIELDS{8'h80}}, '0);
        send_sample(1'b0, {CH_FIELDS{8'h7f}}, '1);
        send_sample(1'b0, '0, 64'h8000_0000_0000_0000);
        send_sample(1'b0, {4{8'h7f, 8'h80}}, 64'h0000_0000_0000_0001);
        send_sample(1'b0, {CH_FIELDS{8'hff}}, 64'h5555_5555_5555_5555);
        send_sample(1'b0, {CH_FIELDS{8'h01}}, 64'haaaa_aaaa_aaaa_aaaa);
        send_sample(1'b0, 64'h8001_7f02_fe40_c0aa, 64'h0123_4567_89ab_cdef);
        send_sample(1'b1, {CH_FIELDS{8'h80}}, 64'hfedc_ba98_7654_3210);
        send_sample(1'b0, 64'h0080_0000_0000_7f00, 64'h0000_0000_ffff_ffff);
        send_sample(1'b1, {CH_FIELDS{8'h55}}, 64'hffff_ffff_0000_0000);

        // A zero limit stops every result.
        drain_block();
        load_limit('0);
        send_sample(1'b0, {CH_FIELDS{8'h80}}, 64'h11);
        send_sample(1'b1, {CH_FIELDS{8'h7f}}, 64'h22);

        // A small limit is reached and later samples are dropped.
        drain_block();
        load_limit(16'd3);
        send_sample(1'b1, {CH_FIELDS{8'h80}}, 64'h31);
        send_sample(1'b0, {CH_FIELDS{8'h7f}}, 64'h32);
        send_sample(1'b0, {CH_FIELDS{8'h03}}, 64'h33);
        send_sample(1'b0, {CH_FIELDS{8'hfd}}, 64'h34);
        send_sample(1'b0, {CH_FIELDS{8'h10}}, 64'h35);
        send_sample(1'b0, {CH_FIELDS{8'h20}}, 64'h36);

        // A raised limit resumes from the stored window.
        drain_block();
        load_limit(16'd10);
        send_sample(1'b0, {CH_FIELDS{8'h40}}, 64'h41);
        send_sample(1'b0, {CH_FIELDS{8'hc0}}, 64'h42);
        send_sample(1'b0, '0, 64'h43);
        send_sample(1'b0, {CH_FIELDS{8'h80}}, 64'h44);

        phase = 0;
        forever begin
            drain_block();
            if (sent_count >= TARGET_ITEMS) break;
            case (phase)
                0:       limit = '1;
                1:       limit = 16'(WINDOW);
                default: begin
                    case ($urandom_range(0, 9))
                        0:       limit = '0;
                        1:       limit = '1;
                        2:       limit = 16'($urandom_range(1, 5));
                        3:       limit = 16'($urandom_range(WINDOW - 1, WINDOW + 1));
                        default: limit = 16'($urandom_range(20, 300));
                    endcase
                end
            endcase
            load_limit(limit);
            s_idle_on  = ($urandom_range(0, 3) != 0);
            m_idle_on  = ($urandom_range(0, 3) != 0);
            full_scale = (phase == 0) || ($urandom_range(0, 6) == 0);
            run_len    = full_scale ? $urandom_range(WINDOW + 2, 2 * WINDOW)
                                    : $urandom_range(20, 150);
            if (run_len > TARGET_ITEMS - sent_count) begin
                run_len = TARGET_ITEMS - sent_count;
            end
            for (int n = 0; n < run_len; n++) begin
                if (n == 0) begin
                    restart = (phase == 0) || ($urandom_range(0, 9) < 7);
                end else begin
                    restart = ($urandom_range(0, 49) == 0);
                end
                send_sample(restart, full_scale ? {CH_FIELDS{8'h80}} : random_lanes(),
                            random_stamp());
            end
            phase++;
        end

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
